[hdl/tsp_swap_hill_climb_unit_macros.svh]
// assertion macros for the swap hill climb unit
`ifndef TSP_SWAP_HILL_CLIMB_UNIT_MACROS_SVH
`define TSP_SWAP_HILL_CLIMB_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk, disabled in reset
`define TSP_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, disabled in reset
`define TSP_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/tsp_shc_pkg.sv]
// shared types and constants of the swap hill climb unit
`default_nettype none

package tsp_shc_pkg;

	localparam int COST_W     = 14;
	localparam int MARGIN_W   = 15;
	localparam int CITY_CNT_W = 4;
	localparam int ITER_W     = 16;
	localparam int CITY_W     = 3;
	localparam int POS_W      = 3;
	localparam int DVAL_W     = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [COST_W-1:0] COST_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_MARGIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CITY_COUNT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT    = 2'd2;

	typedef enum logic [1:0] {
		CMD_LOAD_DIST = 2'd0,
		CMD_LOAD_TOUR = 2'd1,
		CMD_EVAL      = 2'd2,
		CMD_SWAP      = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t              cmd;
		logic [CITY_W-1:0] city_a;
		logic [CITY_W-1:0] city_b;
		logic [DVAL_W-1:0] dist_value;
		logic [POS_W-1:0]  pos_a;
		logic [POS_W-1:0]  pos_b;
	} req_item_t;

	typedef struct packed {
		logic [COST_W-1:0] candidate_cost;
		logic [COST_W-1:0] best_cost;
		logic              accepted;
		logic              status;
	} rsp_item_t;

endpackage

`default_nettype wire

[hdl/tsp_shc_if.sv]
// request, result and configuration channel interfaces
`default_nettype none

interface tsp_shc_req_if import tsp_shc_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tsp_shc_rsp_if import tsp_shc_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface tsp_shc_cfg_if import tsp_shc_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/tsp_swap_hill_climb_unit.sv]
// top level of the two-position swap hill climb unit for open tsp paths
//
// channels: req takes one command item (load distance, load tour position,
// evaluate, try swap), rsp returns exactly one result item per command, cfg
// writes accept_margin, city_count and iteration_limit and is always ready.
// the block takes one item at a time; req.ready is high only while idle.
// load distance writes the entry and then its mirror, load tour writes one
// position, and a swap try past the limit or with a position outside the
// tour answers without a sweep. evaluate and in-range swap sweep the n
// cities in use, and a taken swap is then written back into the tour,
// position a then position b. the sweep reads one tour entry and one
// distance per cycle through the single read port of each ram and adds it
// in one shared saturating adder.
// reset clears the cost, the try count and the config registers to their
// defaults; distance table and tour hold nothing defined until loaded.
// a stalled result sits in the output register; the next item is already
// accepted and worked on, and its result waits until the register frees.
`default_nettype none

`include "tsp_swap_hill_climb_unit_macros.svh"

module tsp_swap_hill_climb_unit import tsp_shc_pkg::*; #(
	parameter int MAX_CITIES = 8,
	parameter int DIST_BITS  = 8
) (
	input wire logic       clk,
	input wire logic       arst_n,
	tsp_shc_req_if.sink    req,
	tsp_shc_rsp_if.source  rsp,
	tsp_shc_cfg_if.sink    cfg
);

	localparam int CW = $clog2(MAX_CITIES);
	localparam int NW = $clog2(MAX_CITIES + 1);
	localparam int PW = (CW > POS_W) ? CW : POS_W;
	localparam int AW = 2 * CW;
	localparam int SW = ((COST_W > DIST_BITS) ? COST_W : DIST_BITS) + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIST2,
		ST_SWEEP,
		ST_DRAIN,
		ST_WB_A,
		ST_WB_B,
		ST_RESP
	} state_t;

	state_t state_q;

	// config registers
	logic signed [MARGIN_W-1:0] margin_q;
	logic [CITY_CNT_W-1:0]      city_cnt_q;
	logic [ITER_W-1:0]          iter_lim_q;

	// item fields and sequencer
	cmd_t                 cmd_q;
	logic [CITY_W-1:0]    ca_q;
	logic [CITY_W-1:0]    cb_q;
	logic [DIST_BITS-1:0] dv_q;
	logic [POS_W-1:0]     pa_q;
	logic [POS_W-1:0]     pb_q;
	logic                 swap_q;
	logic [CW-1:0]        rd_pos_q;
	logic [CW-1:0]        last_pos_q;
	logic [CW-1:0]        prev_q;
	logic [CW-1:0]        val_pa_q;
	logic [CW-1:0]        val_pb_q;
	logic                 t_v_s1;
	logic [CW-1:0]        t_pos_s1;
	logic                 d_v_s2;
	logic [COST_W-1:0]    sum_q;

	// tour state and results
	logic [COST_W-1:0] cost_q;
	logic [ITER_W-1:0] tries_q;
	logic [COST_W-1:0] res_cand_q;
	logic              res_acc_q;
	logic              res_stat_q;
	logic              out_vld_q;
	rsp_item_t         out_item_q;

	// ram ports
	logic                 t_we;
	logic [CW-1:0]        t_waddr;
	logic [CW-1:0]        t_wdata;
	logic [CW-1:0]        t_raddr;
	logic [CW-1:0]        t_rdata;
	logic                 d_we;
	logic [AW-1:0]        d_waddr;
	logic [DIST_BITS-1:0] d_wdata;
	logic [AW-1:0]        d_raddr;
	logic [DIST_BITS-1:0] d_rdata;

	logic                     in_acc;
	logic [NW-1:0]            n_c;
	logic                     dist_ok;
	logic                     tour_ok;
	logic                     swap_ok;
	logic [SW-1:0]            sum_ext;
	logic signed [COST_W+1:0] diff_c;
	logic signed [COST_W+1:0] margin_ext;

	assign in_acc    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp.valid = out_vld_q;
	assign rsp.item  = out_item_q;

	always_comb begin
		if (int'(city_cnt_q) >= MAX_CITIES) begin
			n_c = NW'(MAX_CITIES);
		end else begin
			n_c = NW'(city_cnt_q);
		end
	end

	assign dist_ok = (int'(req.item.city_a) < MAX_CITIES) && (int'(req.item.city_b) < MAX_CITIES);
	assign tour_ok = (int'(req.item.pos_a) < MAX_CITIES) && (int'(req.item.city_a) < MAX_CITIES);
	assign swap_ok = (int'(req.item.pos_a) < int'(n_c)) && (int'(req.item.pos_b) < int'(n_c));

	// shared saturating adder and accept compare
	assign sum_ext    = SW'(sum_q) + SW'(d_rdata);
	assign diff_c     = signed'((COST_W + 2)'(sum_q)) - signed'((COST_W + 2)'(cost_q));
	assign margin_ext = (COST_W + 2)'(margin_q);

	// swapped view of the tour during a try
	always_comb begin
		if (swap_q && (PW'(rd_pos_q) == PW'(pa_q))) begin
			t_raddr = CW'(pb_q);
		end else if (swap_q && (PW'(rd_pos_q) == PW'(pb_q))) begin
			t_raddr = CW'(pa_q);
		end else begin
			t_raddr = rd_pos_q;
		end
	end

	assign d_raddr = {prev_q, t_rdata};

	always_comb begin
		t_we    = 1'b0;
		t_waddr = CW'(req.item.pos_a);
		t_wdata = CW'(req.item.city_a);
		d_we    = 1'b0;
		d_waddr = {CW'(req.item.city_a), CW'(req.item.city_b)};
		d_wdata = DIST_BITS'(req.item.dist_value);
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc && (req.item.cmd == CMD_LOAD_DIST) && dist_ok) begin
					d_we = 1'b1;
				end
				if (in_acc && (req.item.cmd == CMD_LOAD_TOUR) && tour_ok) begin
					t_we = 1'b1;
				end
			end
			ST_DIST2: begin
				d_we    = 1'b1;
				d_waddr = {CW'(cb_q), CW'(ca_q)};
				d_wdata = dv_q;
			end
			ST_WB_A: begin
				t_we    = 1'b1;
				t_waddr = CW'(pa_q);
				t_wdata = val_pa_q;
			end
			ST_WB_B: begin
				t_we    = 1'b1;
				t_waddr = CW'(pb_q);
				t_wdata = val_pb_q;
			end
			default: ;
		endcase
	end

	tsp_shc_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_CITIES)
	) u_tour_ram (
		.clk   (clk),
		.we    (t_we),
		.waddr (t_waddr),
		.wdata (t_wdata),
		.raddr (t_raddr),
		.rdata (t_rdata)
	);

	tsp_shc_ram #(
		.WIDTH (DIST_BITS),
		.DEPTH (1 << AW)
	) u_dist_ram (
		.clk   (clk),
		.we    (d_we),
		.waddr (d_waddr),
		.wdata (d_wdata),
		.raddr (d_raddr),
		.rdata (d_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			margin_q   <= '0;
			city_cnt_q <= CITY_CNT_W'(8);
			iter_lim_q <= ITER_W'(100);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_ACCEPT_MARGIN: margin_q   <= cfg.data[MARGIN_W-1:0];
				CFG_CITY_COUNT:    city_cnt_q <= cfg.data[CITY_CNT_W-1:0];
				CFG_ITER_LIMIT:    iter_lim_q <= cfg.data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cmd_q      <= CMD_LOAD_DIST;
			ca_q       <= '0;
			cb_q       <= '0;
			dv_q       <= '0;
			pa_q       <= '0;
			pb_q       <= '0;
			swap_q     <= 1'b0;
			rd_pos_q   <= '0;
			last_pos_q <= '0;
			prev_q     <= '0;
			val_pa_q   <= '0;
			val_pb_q   <= '0;
			t_v_s1     <= 1'b0;
			t_pos_s1   <= '0;
			d_v_s2     <= 1'b0;
			sum_q      <= '0;
			cost_q     <= '0;
			tries_q    <= '0;
			res_cand_q <= '0;
			res_acc_q  <= 1'b0;
			res_stat_q <= 1'b0;
			out_vld_q  <= 1'b0;
			out_item_q <= '0;
		end else begin
			// sweep pipeline: tour read, distance read, accumulate
			t_v_s1   <= (state_q == ST_SWEEP);
			t_pos_s1 <= rd_pos_q;
			d_v_s2   <= t_v_s1 && (t_pos_s1 != '0);
			if (t_v_s1) begin
				prev_q <= t_rdata;
				if (PW'(t_pos_s1) == PW'(pa_q)) begin
					val_pa_q <= t_rdata;
				end
				if (PW'(t_pos_s1) == PW'(pb_q)) begin
					val_pb_q <= t_rdata;
				end
			end
			if (d_v_s2) begin
				sum_q <= (sum_ext > SW'(COST_MAX)) ? COST_MAX : COST_W'(sum_ext);
			end

			if (out_vld_q && rsp.ready && (state_q != ST_RESP)) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cmd_q      <= req.item.cmd;
						ca_q       <= req.item.city_a;
						cb_q       <= req.item.city_b;
						dv_q       <= DIST_BITS'(req.item.dist_value);
						pa_q       <= req.item.pos_a;
						pb_q       <= req.item.pos_b;
						sum_q      <= '0;
						rd_pos_q   <= '0;
						last_pos_q <= CW'(n_c - NW'(1));
						swap_q     <= 1'b0;
						res_cand_q <= '0;
						res_acc_q  <= 1'b0;
						res_stat_q <= 1'b0;
						unique case (req.item.cmd)
							CMD_LOAD_DIST: begin
								state_q <= dist_ok ? ST_DIST2 : ST_RESP;
							end
							CMD_LOAD_TOUR: begin
								state_q <= ST_RESP;
							end
							CMD_EVAL: begin
								tries_q <= '0;
								state_q <= (n_c != '0) ? ST_SWEEP : ST_DRAIN;
							end
							CMD_SWAP: begin
								if (tries_q >= iter_lim_q) begin
									res_stat_q <= 1'b1;
									state_q    <= ST_RESP;
								end else begin
									tries_q <= tries_q + ITER_W'(1);
									if (swap_ok) begin
										swap_q  <= 1'b1;
										state_q <= ST_SWEEP;
									end else begin
										state_q <= ST_RESP;
									end
								end
							end
						endcase
					end
				end
				ST_DIST2: begin
					state_q <= ST_RESP;
				end
				ST_SWEEP: begin
					rd_pos_q <= rd_pos_q + CW'(1);
					if (rd_pos_q == last_pos_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!t_v_s1 && !d_v_s2) begin
						res_cand_q <= sum_q;
						if (cmd_q == CMD_EVAL) begin
							cost_q  <= sum_q;
							state_q <= ST_RESP;
						end else if (diff_c <= margin_ext) begin
							cost_q    <= sum_q;
							res_acc_q <= 1'b1;
							state_q   <= ST_WB_A;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_WB_A: begin
					state_q <= ST_WB_B;
				end
				ST_WB_B: begin
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					if (!out_vld_q || rsp.ready) begin
						out_vld_q                 <= 1'b1;
						out_item_q.candidate_cost <= res_cand_q;
						out_item_q.best_cost      <= cost_q;
						out_item_q.accepted       <= res_acc_q;
						out_item_q.status         <= res_stat_q;
						state_q                   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`TSP_ASSERT_IMP(a_dist_after_tour, d_v_s2, $past(t_v_s1), "distance read without tour read")
	`TSP_ASSERT_IMP(a_idle_pipe_empty, state_q == ST_IDLE, !t_v_s1 && !d_v_s2, "sweep busy in idle")
	`TSP_ASSERT_IMP(a_wb_only_accepted, state_q == ST_WB_A || state_q == ST_WB_B, res_acc_q,
		"tour written back for a rejected swap")
	`TSP_ASSERT_IMP(a_acc_cost_match, out_vld_q && out_item_q.accepted,
		out_item_q.candidate_cost == out_item_q.best_cost, "accepted cost differs from best")
	`TSP_ASSERT_IMP(a_limit_reject, out_vld_q && out_item_q.status,
		!out_item_q.accepted && (out_item_q.candidate_cost == '0), "limit reject carries a move")
	`TSP_ASSERT_NXT(a_try_counted, in_acc && (req.item.cmd == CMD_SWAP) && (tries_q < iter_lim_q),
		tries_q == ITER_W'($past(tries_q) + ITER_W'(1)), "swap try not counted")

endmodule

`default_nettype wire

[hdl/tsp_shc_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module tsp_shc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[test/tsp_shc_checker.sv]
// watches the swap hill climb channels, predicts each result item and compares
module tsp_shc_checker import tsp_shc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	tsp_shc_req_if    req,
	tsp_shc_rsp_if    rsp,
	tsp_shc_cfg_if    cfg,
	output int        fail_count,
	output int        pending,
	output int        swaps_taken,
	output int        limit_hits
);

	localparam int NCITY = 8;

	logic [DVAL_W-1:0]               dist_tab [NCITY][NCITY];
	logic [NCITY-1:0][CITY_W-1:0]    tour_now;
	logic [COST_W-1:0]               best_now;
	logic [ITER_W-1:0]               tries_used;
	logic signed [MARGIN_W-1:0]      margin_cfg;
	logic [CITY_CNT_W-1:0]           count_cfg;
	logic [ITER_W-1:0]               limit_cfg;
	rsp_item_t                       outcomes_due [$];
	int                              results_seen;

	task automatic flag_error(input string msg);
		$display("checker: result %0d: %s", results_seen, msg);
		fail_count++;
	endtask

	function automatic logic [COST_W-1:0] open_path_cost(
		input logic [NCITY-1:0][CITY_W-1:0] path,
		input int n
	);
		int acc;
		acc = 0;
		for (int i = 0; i + 1 < n; i++) begin
			acc += int'(dist_tab[path[i]][path[i+1]]);
			if (acc > int'(COST_MAX))
				acc = int'(COST_MAX);
		end
		return acc[COST_W-1:0];
	endfunction

	function automatic rsp_item_t climb_step(input req_item_t it);
		rsp_item_t                    r;
		int                           n;
		logic [NCITY-1:0][CITY_W-1:0] trial;
		logic [COST_W-1:0]            cand;
		r = '0;
		n = (count_cfg < NCITY) ? int'(count_cfg) : NCITY;
		case (it.cmd)
			CMD_LOAD_DIST: begin
				dist_tab[it.city_a][it.city_b] = it.dist_value;
				dist_tab[it.city_b][it.city_a] = it.dist_value;
			end
			CMD_LOAD_TOUR: begin
				tour_now[it.pos_a] = it.city_a;
			end
			CMD_EVAL: begin
				r.candidate_cost = open_path_cost(tour_now, n);
				best_now = r.candidate_cost;
				tries_used = '0;
			end
			CMD_SWAP: begin
				if (tries_used >= limit_cfg) begin
					r.status = 1'b1;
					limit_hits++;
				end else begin
					tries_used = tries_used + 1'b1;
					if (int'(it.pos_a) < n && int'(it.pos_b) < n) begin
						trial = tour_now;
						trial[it.pos_a] = tour_now[it.pos_b];
						trial[it.pos_b] = tour_now[it.pos_a];
						cand = open_path_cost(trial, n);
						r.candidate_cost = cand;
						if (int'(cand) - int'(best_now) <= int'(margin_cfg)) begin
							tour_now = trial;
							best_now = cand;
							r.accepted = 1'b1;
							swaps_taken++;
						end
					end
				end
			end
		endcase
		r.best_cost = best_now;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_item_t got;
		rsp_item_t want;
		if (!arst_n) begin
			best_now = '0;
			tries_used = '0;
			margin_cfg = '0;
			count_cfg = 4'd8;
			limit_cfg = 16'd100;
			outcomes_due.delete();
			results_seen = 0;
			fail_count = 0;
			pending = 0;
			swaps_taken = 0;
			limit_hits = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got = rsp.item;
				if (outcomes_due.size() == 0) begin
					flag_error($sformatf("item with nothing outstanding, cost %0d best %0d",
						got.candidate_cost, got.best_cost));
				end else begin
					want = outcomes_due.pop_front();
					if (got.candidate_cost !== want.candidate_cost)
						flag_error($sformatf("candidate_cost %0d, expected %0d",
							got.candidate_cost, want.candidate_cost));
					if (got.best_cost !== want.best_cost)
						flag_error($sformatf("best_cost %0d, expected %0d",
							got.best_cost, want.best_cost));
					if (got.accepted !== want.accepted)
						flag_error($sformatf("accepted %b, expected %b",
							got.accepted, want.accepted));
					if (got.status !== want.status)
						flag_error($sformatf("status %b, expected %b",
							got.status, want.status));
				end
				results_seen++;
			end
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ACCEPT_MARGIN: margin_cfg = cfg.data[MARGIN_W-1:0];
					CFG_CITY_COUNT:    count_cfg = cfg.data[CITY_CNT_W-1:0];
					CFG_ITER_LIMIT:    limit_cfg = cfg.data[ITER_W-1:0];
					default: ;
				endcase
			end
			if (req.valid && req.ready)
				outcomes_due.insert(outcomes_due.size(), climb_step(req.item));
			pending = outcomes_due.size();
		end
	end

endmodule

[test/tb_top.sv]
// stimulus and verdict for the swap hill climb unit
module tb_top;
	import tsp_shc_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   swaps_taken;
	int   limit_hits;
	bit   steady = 1'b0;
	int   stall_left = 0;
	int   city_setting = 8;
	int   reg_writes = 0;
	int   sent_by_cmd [4] = '{0, 0, 0, 0};

	tsp_shc_req_if req_ch ();
	tsp_shc_rsp_if rsp_ch ();
	tsp_shc_cfg_if cfg_ch ();

	tsp_swap_hill_climb_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	tsp_shc_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg         (cfg_ch),
		.fail_count  (fail_count),
		.pending     (pending),
		.swaps_taken (swaps_taken),
		.limit_hits  (limit_hits)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic int idle_span();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	function automatic int tour_pos(input int n_use);
		if (n_use > 0 && $urandom_range(0, 99) < 85)
			return $urandom_range(0, n_use - 1);
		return $urandom_range(0, 7);
	endfunction

	always @(negedge clk) begin
		if (stall_left > 0) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 99) < 20) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= idle_span() - 1;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	task automatic send_item(input req_item_t it);
		int gap;
		gap = (steady || $urandom_range(0, 99) < 60) ? 0 : idle_span();
		if (gap > 0) begin
			@(negedge clk);
			req_ch.valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		req_ch.valid <= 1'b1;
		req_ch.item <= it;
		do @(posedge clk); while (!req_ch.ready);
		sent_by_cmd[int'(it.cmd)]++;
	endtask

	task automatic send_fields(input cmd_t c, input int a, input int b, input int d,
			input int pa, input int pb);
		req_item_t   it;
		logic [31:0] bits;
		bits = $urandom;
		it = bits[$bits(req_item_t)-1:0];
		it.cmd = c;
		it.city_a = a[CITY_W-1:0];
		it.city_b = b[CITY_W-1:0];
		it.dist_value = d[DVAL_W-1:0];
		it.pos_a = pa[POS_W-1:0];
		it.pos_b = pb[POS_W-1:0];
		send_item(it);
	endtask

	task automatic settle();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		if (idx == CFG_CITY_COUNT)
			city_setting = int'(val[CITY_CNT_W-1:0]);
		reg_writes++;
	endtask

	initial begin
		int          order [8];
		int          j;
		int          tmp;
		int          n_use;
		int          r;
		int          m;
		int          phase_len;
		req_item_t   it;
		logic [31:0] bits;

		req_ch.valid = 1'b0;
		req_ch.item = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_ACCEPT_MARGIN;
		cfg_ch.data = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// fill the whole distance table and the tour with a shuffled order
		for (int a = 0; a < 8; a++)
			for (int b = a; b < 8; b++)
				send_fields(CMD_LOAD_DIST, a, b, $urandom_range(0, 255), 0, 0);
		for (int i = 0; i < 8; i++)
			order[i] = i;
		for (int i = 7; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (int i = 0; i < 8; i++)
			send_fields(CMD_LOAD_TOUR, order[i], 0, 0, i, 0);

		// directed corners
		send_fields(CMD_SWAP, 0, 0, 0, 1, 2);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 3, 3);
		send_fields(CMD_SWAP, 0, 0, 0, 0, 7);
		send_fields(CMD_LOAD_DIST, 7, 7, 255, 0, 0);
		send_fields(CMD_LOAD_DIST, 6, 2, 255, 0, 0);
		send_fields(CMD_LOAD_DIST, 1, 5, 0, 0, 0);
		send_fields(CMD_LOAD_TOUR, 7, 0, 0, 7, 0);
		send_fields(CMD_LOAD_TOUR, 0, 0, 0, 0, 0);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 7, 0);
		settle();
		write_reg(CFG_ACCEPT_MARGIN, 16'h3fff);
		send_fields(CMD_SWAP, 0, 0, 0, 2, 5);
		settle();
		write_reg(CFG_ACCEPT_MARGIN, 16'h4000);
		send_fields(CMD_SWAP, 0, 0, 0, 2, 5);
		settle();
		write_reg(CFG_CITY_COUNT, 16'd3);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 2, 6);
		send_fields(CMD_SWAP, 0, 0, 0, 7, 0);
		settle();
		write_reg(CFG_ACCEPT_MARGIN, 16'd0);
		write_reg(CFG_CITY_COUNT, 16'd2);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 0, 1);
		settle();
		write_reg(CFG_CITY_COUNT, 16'd1);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 0, 0);
		settle();
		write_reg(CFG_CITY_COUNT, 16'd0);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 0, 0);
		settle();
		write_reg(CFG_CITY_COUNT, 16'd15);
		write_reg(CFG_ITER_LIMIT, 16'd0);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 1, 4);
		settle();
		write_reg(CFG_ITER_LIMIT, 16'd2);
		send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
		send_fields(CMD_SWAP, 0, 0, 0, 1, 4);
		send_fields(CMD_SWAP, 0, 0, 0, 2, 6);
		send_fields(CMD_SWAP, 0, 0, 0, 3, 5);

		// random phases, each under its own register setting
		for (int phase = 0; phase < 12; phase++) begin
			settle();
			steady = (phase % 4 == 1);
			r = $urandom_range(0, 99);
			if (r < 8)
				write_reg(CFG_ACCEPT_MARGIN, 16'h3fff);
			else if (r < 15)
				write_reg(CFG_ACCEPT_MARGIN, 16'h4000);
			else begin
				m = int'($urandom_range(0, 60)) - 30;
				write_reg(CFG_ACCEPT_MARGIN, 16'(m) & 16'h7fff);
			end
			if ($urandom_range(0, 99) < 20)
				write_reg(CFG_CITY_COUNT, 16'($urandom_range(0, 15)));
			else
				write_reg(CFG_CITY_COUNT, 16'($urandom_range(3, 8)));
			r = $urandom_range(0, 99);
			if (r < 10)
				write_reg(CFG_ITER_LIMIT, 16'd0);
			else if (r < 20)
				write_reg(CFG_ITER_LIMIT, 16'hffff);
			else if (r < 35)
				write_reg(CFG_ITER_LIMIT, 16'($urandom_range(0, 65535)));
			else
				write_reg(CFG_ITER_LIMIT, 16'($urandom_range(4, 40)));
			n_use = (city_setting < 8) ? city_setting : 8;

			send_fields(CMD_EVAL, 0, 0, 0, 0, 0);
			phase_len = $urandom_range(35, 60);
			for (int k = 0; k < phase_len; k++) begin
				bits = $urandom;
				it = bits[$bits(req_item_t)-1:0];
				r = $urandom_range(0, 99);
				if (r < 70) begin
					it.cmd = CMD_SWAP;
					it.pos_a = POS_W'(tour_pos(n_use));
					it.pos_b = POS_W'(tour_pos(n_use));
				end else if (r < 78) begin
					it.cmd = CMD_EVAL;
				end else if (r < 89) begin
					it.cmd = CMD_LOAD_DIST;
				end else begin
					it.cmd = CMD_LOAD_TOUR;
				end
				send_item(it);
			end
		end
		steady = 1'b0;

		settle();
		repeat (20) @(negedge clk);
		$display("covered %0d items: %0d distance loads, %0d tour loads, %0d evaluations, %0d swaps",
			sent_by_cmd[0] + sent_by_cmd[1] + sent_by_cmd[2] + sent_by_cmd[3],
			sent_by_cmd[0], sent_by_cmd[1], sent_by_cmd[2], sent_by_cmd[3]);
		$display("%0d register writes, %0d swaps taken, %0d rejected at the try limit, %0d errors",
			reg_writes, swaps_taken, limit_hits, fail_count);
		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout waiting on a handshake");
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
